FILE: rtl/page_replacement_fifo_lru_assert.svh
// Assertion helpers, clocked on clk and disabled while rst is high.
`ifndef PAGE_REPLACEMENT_FIFO_LRU_ASSERT_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_ASSERT_SVH

// a in this cycle implies b in the same cycle
`define PRFL_ASSERT_NOW(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("page replacement: same-cycle check failed");

// a in this cycle implies b in the next cycle
`define PRFL_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("page replacement: next-cycle check failed");

`endif

FILE: rtl/prfl_pkg.sv
`timescale 1ns / 1ps
package prfl_pkg;

  localparam int SLOT_W  = 4;   // width of the slot result fields
  localparam int TOTAL_W = 32;  // width of the fault totals
  localparam int CFG_W   = 5;   // width of the frame count register

  // sequencer strobes shared by both frame sets
  typedef struct packed {
    logic clear;   // new beat taken: reset the scan results
    logic scan;    // compare the slot at the scan index
    logic commit;  // apply the replacement decision
  } prfl_ctl_t;

endpackage

FILE: rtl/prfl_fifo.sv
`timescale 1ns / 1ps
module prfl_fifo import prfl_pkg::*; #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16,
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int CNT_W = $clog2(MAX_FRAMES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  prfl_ctl_t            ctl,
  input  logic [IDX_W-1:0]     idx,
  input  logic [CNT_W-1:0]     cap,
  input  logic [PAGE_BITS-1:0] page,
  output logic                 fault,
  output logic [IDX_W-1:0]     slot
);

  logic [PAGE_BITS-1:0] pages [MAX_FRAMES];
  logic [CNT_W-1:0]     filled;
  logic [IDX_W-1:0]     front;
  logic                 hit;
  logic [IDX_W-1:0]     hit_slot;

  logic [CNT_W-1:0] n;
  logic             in_range;
  logic             full;
  logic [IDX_W-1:0] evict_slot;
  logic [IDX_W-1:0] front_next;

  always_comb begin
    n          = (filled < cap) ? filled : cap;
    in_range   = CNT_W'(idx) < n;
    full       = !(filled < cap);
    evict_slot = (CNT_W'(front) < cap) ? front : '0;
    front_next = ((CNT_W'(evict_slot) + CNT_W'(1)) >= cap) ? '0 : evict_slot + IDX_W'(1);
    if (hit) begin
      slot = hit_slot;
    end else if (full) begin
      slot = evict_slot;
    end else begin
      slot = filled[IDX_W-1:0];
    end
    fault = !hit;
  end

  // one comparator, one slot per cycle; first match wins
  always_ff @(posedge clk) begin
    if (rst) begin
      hit      <= 1'b0;
      hit_slot <= '0;
    end else if (ctl.clear) begin
      hit      <= 1'b0;
      hit_slot <= '0;
    end else if (ctl.scan && in_range && !hit && (pages[idx] == page)) begin
      hit      <= 1'b1;
      hit_slot <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      front  <= '0;
    end else if (ctl.commit && !hit) begin
      if (full) begin
        front <= front_next;
      end else begin
        filled <= filled + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && !hit) begin
      pages[slot] <= page;
    end
  end

endmodule

FILE: rtl/prfl_lru.sv
`timescale 1ns / 1ps
module prfl_lru import prfl_pkg::*; #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16,
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int CNT_W = $clog2(MAX_FRAMES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  prfl_ctl_t            ctl,
  input  logic [IDX_W-1:0]     idx,
  input  logic [CNT_W-1:0]     cap,
  input  logic [PAGE_BITS-1:0] page,
  output logic                 fault,
  output logic [IDX_W-1:0]     slot
);

  localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(MAX_FRAMES - 1);

  logic [PAGE_BITS-1:0] pages [MAX_FRAMES];
  logic [IDX_W-1:0]     rank  [MAX_FRAMES];  // 0 = most recent
  logic [CNT_W-1:0]     filled;
  logic                 hit;
  logic [IDX_W-1:0]     hit_slot;
  logic [IDX_W-1:0]     hit_rank;
  logic [IDX_W-1:0]     best;
  logic [IDX_W-1:0]     victim;

  logic [CNT_W-1:0]      n;
  logic                  in_range;
  logic                  full;
  logic [MAX_FRAMES-1:0] age;

  always_comb begin
    n        = (filled < cap) ? filled : cap;
    in_range = CNT_W'(idx) < n;
    full     = !(filled < cap);
    if (hit) begin
      slot = hit_slot;
    end else if (full) begin
      slot = victim;
    end else begin
      slot = filled[IDX_W-1:0];
    end
    fault = !hit;
    // on a hit only slots younger than the hit one move up
    for (int i = 0; i < MAX_FRAMES; i++) begin
      age[i] = (CNT_W'(i) < n) && (IDX_W'(i) != slot) && (rank[i] != RANK_MAX) &&
               (!hit || (rank[i] < hit_rank));
    end
  end

  // shared comparator: page match and oldest-rank search in one pass
  always_ff @(posedge clk) begin
    if (rst) begin
      hit      <= 1'b0;
      hit_slot <= '0;
      hit_rank <= '0;
      best     <= '0;
      victim   <= '0;
    end else if (ctl.clear) begin
      hit      <= 1'b0;
      hit_slot <= '0;
      hit_rank <= '0;
      best     <= '0;
      victim   <= '0;
    end else if (ctl.scan && in_range) begin
      if (!hit && (pages[idx] == page)) begin
        hit      <= 1'b1;
        hit_slot <= idx;
        hit_rank <= rank[idx];
      end
      if ((idx == '0) || (rank[idx] > best)) begin
        best   <= rank[idx];
        victim <= idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (ctl.commit && !hit && !full) begin
      filled <= filled + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (IDX_W'(i) == slot) begin
          rank[i] <= '0;
        end else if (age[i]) begin
          rank[i] <= rank[i] + IDX_W'(1);
        end
      end
      if (!hit) begin
        pages[slot] <= page;
      end
    end
  end

endmodule

FILE: rtl/page_replacement_fifo_lru.sv
`timescale 1ns / 1ps
// FIFO and LRU page replacement on one reference stream.
// Input channel: page with page_valid / page_stall; a beat is taken when
//   valid is high and stall is low. Stall is high while a reference is in work.
// Output channel: result_valid / result_stall with hit/fault, slot and a
//   saturating fault total per policy. The result sits in an output register,
//   so the next page beat can be taken while a result waits for the receiver.
// Sequence: take the beat, scan the active frames one slot at a time
//   (a single comparator per set walks the slots), then commit.
// Receiver stall: commit waits until the output register is free, so the
//   set state is never updated ahead of its result.
// Config: cfg_write / cfg_data set the frame count (0 acts as 1, values above
//   MAX_FRAMES act as MAX_FRAMES); write only while the block is idle.
// Reset (rst, synchronous): sets empty, fault totals zero, frame count
//   MAX_FRAMES. No clearing pass; the block is ready the cycle after reset.
`include "page_replacement_fifo_lru_assert.svh"
module page_replacement_fifo_lru import prfl_pkg::*; #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 page_valid,
  output logic                 page_stall,
  input  logic [PAGE_BITS-1:0] page,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 fifo_fault,
  output logic [SLOT_W-1:0]    fifo_slot,
  output logic                 lru_fault,
  output logic [SLOT_W-1:0]    lru_slot,
  output logic [TOTAL_W-1:0]   fifo_fault_total,
  output logic [TOTAL_W-1:0]   lru_fault_total,
  input  logic                 cfg_write,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int FC_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]           state;
  logic [IDX_W-1:0]     idx;
  logic [PAGE_BITS-1:0] page_q;
  logic [FC_W-1:0]      frames_in_use;

  logic [FC_W-1:0]  cap_wide;
  logic [CNT_W-1:0] cap;
  logic             accept;
  logic             out_free;
  logic             scan_last;
  prfl_ctl_t        ctl;

  logic                    fifo_fault_w;
  logic [IDX_W-1:0]        fifo_slot_w;
  logic                    lru_fault_w;
  logic [IDX_W-1:0]        lru_slot_w;
  logic [IDX_W+SLOT_W-1:0] fifo_slot_ext;
  logic [IDX_W+SLOT_W-1:0] lru_slot_ext;

  // active frame count, clamped to 1..MAX_FRAMES
  always_comb begin
    cap_wide = frames_in_use;
    if (cap_wide == '0) begin
      cap_wide = FC_W'(1);
    end else if (cap_wide > FC_W'(MAX_FRAMES)) begin
      cap_wide = FC_W'(MAX_FRAMES);
    end
    cap = cap_wide[CNT_W-1:0];
  end

  assign page_stall = (state != ST_IDLE);
  assign accept     = page_valid && !page_stall;
  assign out_free   = !result_valid || !result_stall;
  assign scan_last  = (CNT_W'(idx) + CNT_W'(1)) == cap;

  assign ctl.clear  = accept;
  assign ctl.scan   = (state == ST_SCAN);
  assign ctl.commit = (state == ST_COMMIT) && out_free;

  assign fifo_slot_ext = {{SLOT_W{1'b0}}, fifo_slot_w};
  assign lru_slot_ext  = {{SLOT_W{1'b0}}, lru_slot_w};

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FC_W'(MAX_FRAMES);
    end else if (cfg_write) begin
      frames_in_use <= FC_W'(cfg_data);
    end
  end

  // sequencer: take beat, walk slots, commit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
            idx   <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state <= ST_COMMIT;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_COMMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page_q <= page;
    end
  end

  prfl_fifo #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .idx   (idx),
    .cap   (cap),
    .page  (page_q),
    .fault (fifo_fault_w),
    .slot  (fifo_slot_w)
  );

  prfl_lru #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_lru (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .idx   (idx),
    .cap   (cap),
    .page  (page_q),
    .fault (lru_fault_w),
    .slot  (lru_slot_w)
  );

  // output register and saturating totals
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid     <= 1'b0;
      fifo_fault_total <= '0;
      lru_fault_total  <= '0;
    end else begin
      if (ctl.commit) begin
        result_valid <= 1'b1;
        if (fifo_fault_w && !(&fifo_fault_total)) begin
          fifo_fault_total <= fifo_fault_total + TOTAL_W'(1);
        end
        if (lru_fault_w && !(&lru_fault_total)) begin
          lru_fault_total <= lru_fault_total + TOTAL_W'(1);
        end
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      fifo_fault <= fifo_fault_w;
      fifo_slot  <= fifo_slot_ext[SLOT_W-1:0];
      lru_fault  <= lru_fault_w;
      lru_slot   <= lru_slot_ext[SLOT_W-1:0];
    end
  end

  // a taken beat starts the scan at slot 0
  `PRFL_ASSERT_NEXT(a_accept_starts_scan, accept, (state == ST_SCAN) && (idx == '0))
  // the scan index never walks past the active frames
  `PRFL_ASSERT_NOW(a_idx_in_range, state == ST_SCAN, CNT_W'(idx) < cap)
  // a blocked commit holds the sequencer and the pending result
  `PRFL_ASSERT_NEXT(a_commit_waits, (state == ST_COMMIT) && !out_free,
                    (state == ST_COMMIT) && result_valid)
  // totals never go backwards
  `PRFL_ASSERT_NEXT(a_totals_monotonic, 1'b1,
                    (fifo_fault_total >= $past(fifo_fault_total)) &&
                    (lru_fault_total >= $past(lru_fault_total)))

endmodule

FILE: bench/tb_page_replacement_fifo_lru.sv
`timescale 1ns / 1ps
// Bench for page_replacement_fifo_lru.
// A short directed run comes first. Then random phases run, each at its own
// frame count, with per-beat gaps on the page side and stalls on the result side unless a side runs calm.
module tb_page_replacement_fifo_lru;
  import prfl_pkg::*;

  localparam int FRAME_MAX  = 16;
  localparam int PAGE_W     = 16;
  localparam int NO_CEILING = 32'h7FFF_FFFF;  // ageing bound when every slot ages
  localparam int PHASES     = 24;
  localparam int PHASE_REFS = 64;

  // one result beat, both policies side by side
  typedef struct packed {
    logic               fifo_fault;
    logic [SLOT_W-1:0]  fifo_slot;
    logic               lru_fault;
    logic [SLOT_W-1:0]  lru_slot;
    logic [TOTAL_W-1:0] fifo_total;
    logic [TOTAL_W-1:0] lru_total;
  } outcome_t;

  // Shadow of both frame sets. Each accepted page is run through it at once,
  // and the outcome is queued until the matching result beat turns up.
  class replacement_board;
    int                 frames;
    logic [PAGE_W-1:0]  fifo_pages [FRAME_MAX];
    int                 fifo_filled;
    int                 fifo_front;
    logic [PAGE_W-1:0]  lru_pages [FRAME_MAX];
    int                 lru_rank [FRAME_MAX];
    int                 lru_filled;
    logic [TOTAL_W-1:0] fifo_total;
    logic [TOTAL_W-1:0] lru_total;
    outcome_t           due_outcomes [$];
    int                 bad_beats;

    function new();
      frames      = FRAME_MAX;
      fifo_filled = 0;
      fifo_front  = 0;
      lru_filled  = 0;
      fifo_total  = '0;
      lru_total   = '0;
      bad_beats   = 0;
      foreach (lru_rank[i]) lru_rank[i] = 0;
    endfunction

    function void note_failure(string msg);
      bad_beats++;
      if (bad_beats <= 10) $display("%s", msg);
    endfunction

    // every searched slot except skip gets older if it was younger than below
    function void age_ranks(int n, int below, int skip);
      int i;
      for (i = 0; i < n; i++)
        if (i != skip && lru_rank[i] < below && lru_rank[i] < FRAME_MAX - 1)
          lru_rank[i]++;
    endfunction

    function void note_reference(logic [PAGE_W-1:0] pg);
      outcome_t o;
      int       cap, n, i, slot, best;
      bit       hit;
      cap = (frames < 1) ? 1 : (frames > FRAME_MAX) ? FRAME_MAX : frames;

      // FIFO set
      n    = (fifo_filled < cap) ? fifo_filled : cap;
      hit  = 0;
      slot = 0;
      for (i = 0; i < n; i++)
        if (!hit && fifo_pages[i] == pg) begin
          hit  = 1;
          slot = i;
        end
      if (!hit) begin
        if (fifo_filled < cap) begin
          slot = fifo_filled;
          fifo_filled++;
        end else begin
          // a front pointer left beyond a lowered count restarts at slot 0
          slot       = (fifo_front < cap) ? fifo_front : 0;
          fifo_front = (slot + 1 >= cap) ? 0 : slot + 1;
        end
        fifo_pages[slot] = pg;
        if (fifo_total != '1) fifo_total++;
      end
      o.fifo_fault = !hit;
      o.fifo_slot  = SLOT_W'(slot);

      // LRU set
      n    = (lru_filled < cap) ? lru_filled : cap;
      hit  = 0;
      slot = 0;
      for (i = 0; i < n; i++)
        if (!hit && lru_pages[i] == pg) begin
          hit  = 1;
          slot = i;
        end
      if (hit) begin
        age_ranks(n, lru_rank[slot], slot);
        lru_rank[slot] = 0;
      end else begin
        if (lru_filled < cap) begin
          slot = lru_filled;
          age_ranks(n, NO_CEILING, slot);
          lru_filled++;
        end else begin
          // oldest rank loses; ties go to the lowest slot
          best = 0;
          slot = 0;
          for (i = 0; i < n; i++)
            if (i == 0 || lru_rank[i] > best) begin
              best = lru_rank[i];
              slot = i;
            end
          age_ranks(n, NO_CEILING, slot);
        end
        lru_pages[slot] = pg;
        lru_rank[slot]  = 0;
        if (lru_total != '1) lru_total++;
      end
      o.lru_fault  = !hit;
      o.lru_slot   = SLOT_W'(slot);
      o.fifo_total = fifo_total;
      o.lru_total  = lru_total;
      due_outcomes.push_back(o);
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (due_outcomes.size() == 0) begin
        note_failure("result beat arrived with nothing outstanding");
        return;
      end
      want = due_outcomes.pop_front();
      if (got.fifo_fault !== want.fifo_fault || got.fifo_slot !== want.fifo_slot ||
          got.lru_fault !== want.lru_fault || got.lru_slot !== want.lru_slot ||
          got.fifo_total !== want.fifo_total || got.lru_total !== want.lru_total)
        note_failure($sformatf({"mismatch: expected fifo %0d/%0d/%0d lru %0d/%0d/%0d,",
                                " got fifo %0d/%0d/%0d lru %0d/%0d/%0d"},
                               want.fifo_fault, want.fifo_slot, want.fifo_total,
                               want.lru_fault, want.lru_slot, want.lru_total,
                               got.fifo_fault, got.fifo_slot, got.fifo_total,
                               got.lru_fault, got.lru_slot, got.lru_total));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               page_valid;
  logic               page_stall;
  logic [PAGE_W-1:0]  page;
  logic               result_valid;
  logic               result_stall;
  logic               fifo_fault;
  logic [SLOT_W-1:0]  fifo_slot;
  logic               lru_fault;
  logic [SLOT_W-1:0]  lru_slot;
  logic [TOTAL_W-1:0] fifo_fault_total;
  logic [TOTAL_W-1:0] lru_fault_total;
  logic               cfg_write;
  logic [CFG_W-1:0]   cfg_data;

  replacement_board board;
  bit               calm_send;  // no gaps between page beats
  bit               calm_recv;  // no stalls on the result side

  page_replacement_fifo_lru #(
    .MAX_FRAMES (FRAME_MAX),
    .PAGE_BITS  (PAGE_W)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .page_valid       (page_valid),
    .page_stall       (page_stall),
    .page             (page),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .fifo_fault       (fifo_fault),
    .fifo_slot        (fifo_slot),
    .lru_fault        (lru_fault),
    .lru_slot         (lru_slot),
    .fifo_fault_total (fifo_fault_total),
    .lru_fault_total  (lru_fault_total),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  // Page side. Entered and left at a rising edge. Stall is looked at on the
  // falling edge, where everything driven at the last rising edge has settled;
  // the beat is then taken at the following rising edge.
  task automatic send_page(input logic [PAGE_W-1:0] pg);
    int gap;
    bit go;
    gap = calm_send ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      page_valid <= 1'b0;
      page       <= PAGE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    page_valid <= 1'b1;
    page       <= pg;
    go = 0;
    while (!go) begin
      @(negedge clk);
      go = !page_stall;
      @(posedge clk);
    end
    board.note_reference(pg);
  endtask

  // hold the page side off until every outstanding result has been checked
  task automatic drain();
    page_valid <= 1'b0;
    while (board.due_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic set_frames(input logic [CFG_W-1:0] count);
    cfg_write <= 1'b1;
    cfg_data  <= count;
    @(posedge clk);
    board.frames = count;
    cfg_write <= 1'b0;
  endtask

  // Result side: a random stall before each beat, then take it. Fields are
  // captured on the falling edge ahead of the accepting rising edge.
  initial begin : result_sink
    int       hold;
    bit       took;
    outcome_t got;
    result_stall <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      hold = calm_recv ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      took = 0;
      while (!took) begin
        @(negedge clk);
        if (result_valid === 1'b1) begin
          got.fifo_fault = fifo_fault;
          got.fifo_slot  = fifo_slot;
          got.lru_fault  = lru_fault;
          got.lru_slot   = lru_slot;
          got.fifo_total = fifo_fault_total;
          got.lru_total  = lru_fault_total;
          board.check_result(got);
          took = 1;
        end
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0]  opening_counts [6] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd15};
    logic [PAGE_W-1:0] pool [32];
    logic [PAGE_W-1:0] pg;
    logic [CFG_W-1:0]  count;
    int                p, k, eff, pool_n;
    board      = new();
    calm_send  = 0;
    calm_recv  = 0;
    rst        <= 1'b1;
    page_valid <= 1'b0;
    page       <= '0;
    cfg_write  <= 1'b0;
    cfg_data   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // all sixteen frames from reset: extreme pages, then hits on them
    send_page(16'h0000); send_page(16'hFFFF); send_page(16'hAAAA);
    send_page(16'h5555); send_page(16'h0001); send_page(16'h0000);
    send_page(16'hFFFF);
    // lowered to three with five already filled: set counts as full, front wraps
    drain(); set_frames(5'd3);
    send_page(16'h0002); send_page(16'h0005); send_page(16'h0006);
    send_page(16'h0007); send_page(16'hAAAA);
    // one frame: front pointer left beyond the count goes back to slot 0
    drain(); set_frames(5'd1);
    send_page(16'h0000); send_page(16'h0000); send_page(16'h0008);
    // zero acts as one
    drain(); set_frames(5'd0);
    send_page(16'h0009); send_page(16'h0009);
    // above the limit acts as sixteen; stale slots bring back duplicates and
    // equal ranks
    drain(); set_frames(5'd31);
    send_page(16'h0005); send_page(16'h0006); send_page(16'h0009);
    send_page(16'h0001); send_page(16'h5555); send_page(16'hFFFF);

    // Random phases. Pages mostly come from a small pool sized around the frame
    // count, so hits, evictions and wraps all turn up; the rest are wild.
    for (p = 0; p < PHASES; p++) begin
      drain();
      if (p < 6)
        count = opening_counts[p];
      else if ($urandom_range(0, 7) == 0)
        count = CFG_W'($urandom_range(0, 31));
      else
        count = CFG_W'($urandom_range(1, FRAME_MAX));
      set_frames(count);
      eff    = (count < 1) ? 1 : (count > FRAME_MAX) ? FRAME_MAX : count;
      pool_n = $urandom_range(1, eff + 6);
      for (k = 0; k < pool_n; k++)
        pool[k] = ($urandom_range(0, 15) == 0) ? '1 : PAGE_W'($urandom_range(0, 65535));
      calm_send = ($urandom_range(0, 3) == 0);
      calm_recv = ($urandom_range(0, 3) == 0);
      for (k = 0; k < PHASE_REFS; k++) begin
        if ($urandom_range(0, 7) == 0)
          pg = PAGE_W'($urandom);
        else
          pg = pool[$urandom_range(0, pool_n - 1)];
        send_page(pg);
      end
    end

    drain();
    repeat (FRAME_MAX + 8) @(posedge clk);
    if (board.bad_beats == 0)
      $display("page_replacement_fifo_lru regression: pass");
    else
      $display("page_replacement_fifo_lru regression: fail");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #(10_000_000);
    $display("page_replacement_fifo_lru regression: fail");
    $finish;
  end

endmodule

FILE: page_replacement_fifo_lru.f
+incdir+rtl
rtl/prfl_pkg.sv
rtl/prfl_fifo.sv
rtl/prfl_lru.sv
rtl/page_replacement_fifo_lru.sv
bench/tb_page_replacement_fifo_lru.sv
